// ----- rtl/core/moving_average_window_macros.svh -----
// Assertion macros for the moving average window block
`ifndef MOVING_AVERAGE_WINDOW_MACROS_SVH
`define MOVING_AVERAGE_WINDOW_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MAVG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mavg check failed");
`define MAVG_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mavg check failed");
`else
`define MAVG_ASSERT_IMP(label, clk, rst, ante, cons)
`define MAVG_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/mavg_pkg.sv -----
// Shared types, constants and helpers for the moving average window
package mavg_pkg;
   localparam int MAX_WINDOW_DEF = 64;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int SUM_BITS = 22;
   localparam int WSIZE_BITS = 7;
   localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = 7'd64;

   typedef enum logic {
      REQ_ADD  = 1'b0,
      REQ_FILL = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_LOOK,
      ST_UPD,
      ST_SCAN,
      ST_PREP,
      ST_DIV,
      ST_HOLD
   } state_type;

   // clamp window size to 1..max_win
   function automatic logic [WSIZE_BITS-1:0] eff_size(input logic [WSIZE_BITS-1:0] wsize,
                                                      input int max_win);
      logic [WSIZE_BITS-1:0] n;
      n = wsize;
      if (wsize == '0) begin
         n = WSIZE_BITS'(1);
      end else if (int'(wsize) > max_win) begin
         n = WSIZE_BITS'(max_win);
      end
      return n;
   endfunction
endpackage

// ----- rtl/core/mavg_req_if.sv -----
// Request channel: one sample word or fill word
interface mavg_req_if #(
   parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic signed [SAMPLE_BITS-1:0] sample_value;

   modport source (output valid, output req_type, output sample_value, input ready);
   modport sink (input valid, input req_type, input sample_value, output ready);
endinterface

// ----- rtl/core/mavg_rsp_if.sv -----
// Response channel: window average and window sum
interface mavg_rsp_if #(
   parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
);
   import mavg_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] average;
   logic signed [SUM_BITS-1:0]    window_sum;

   modport source (output valid, output average, output window_sum, input ready);
   modport sink (input valid, input average, input window_sum, output ready);
endinterface

// ----- rtl/core/mavg_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module mavg_ram #(
   parameter int WIDTH = mavg_pkg::SAMPLE_BITS_DEF,
   parameter int DEPTH = mavg_pkg::MAX_WINDOW_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/core/moving_average_window.sv -----
// Boxcar moving average over a ring of the last window_size samples.
// An add word, once accepted, passes a RAM read, a running-sum update, a sign step, ACC
// one-bit divide steps with ACC = SAMPLE_BITS+7, 23 by default, and the output load, which
// waits in ST_HOLD while the output register is still full; when the window size differs
// from the one used for the previous sum, a full rescan of the window comes before the sign
// step. A fill word does one RAM write per window entry, then the divide.
// The one-read-per-cycle sample RAM and the bit-serial divider set this sequence; one word is
// in work at a time and the next is taken the cycle after the result moves into the output
// register, so a new word is not taken before the last one is through. Sample entries read
// as zero until first written, so no clearing pass is needed after reset.
`include "moving_average_window_macros.svh"

module moving_average_window #(
   parameter int MAX_WINDOW  = mavg_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [mavg_pkg::WSIZE_BITS-1:0]  csr_write_data,
   mavg_req_if.sink                         req_bus,
   mavg_rsp_if.source                       rsp_bus
);
   import mavg_pkg::*;

   localparam int PTR_W  = $clog2(MAX_WINDOW);
   localparam int CMP_W  = (PTR_W + 1 > WSIZE_BITS) ? PTR_W + 1 : WSIZE_BITS;
   localparam int ACC_W  = SAMPLE_BITS + WSIZE_BITS;
   localparam int DCNT_W = $clog2(ACC_W);
   localparam int REM_W  = WSIZE_BITS + 1;

   state_type                     state_ff, state_in;
   logic [WSIZE_BITS-1:0]         wsize_ff, wsize_in;
   logic [PTR_W-1:0]              wp_ff, wp_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic [WSIZE_BITS-1:0]         sum_n_ff, sum_n_in;
   req_kind_type                  kind_ff, kind_in;
   logic signed [SAMPLE_BITS-1:0] v_ff, v_in;
   logic [WSIZE_BITS-1:0]         cnt_ff, cnt_in;
   logic [DCNT_W-1:0]             dcnt_ff, dcnt_in;
   logic [ACC_W-1:0]              dq_ff, dq_in;
   logic [REM_W-1:0]              rem_ff, rem_in;
   logic                          neg_ff, neg_in;
   logic [MAX_WINDOW-1:0]         vld_ff, vld_in;
   logic                          vld_q_ff, vld_q_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] avg_ff, avg_in;
   logic signed [SUM_BITS-1:0]    wsum_ff, wsum_in;

   logic [WSIZE_BITS-1:0]         n;
   logic [PTR_W:0]                p_wide;
   logic [PTR_W-1:0]              ptr_next;
   logic                          ram_we;
   logic [PTR_W-1:0]              ram_waddr;
   logic [PTR_W-1:0]              ram_raddr;
   logic [SAMPLE_BITS-1:0]        ram_rdata;
   logic signed [ACC_W-1:0]       old_ext;
   logic signed [ACC_W-1:0]       v_ext;
   logic [REM_W-1:0]              trial;
   logic                          qbit;
   logic                          out_free;

   mavg_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (v_ff),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign n        = eff_size(wsize_ff, MAX_WINDOW);
   assign p_wide   = {1'b0, wp_ff} + (PTR_W + 1)'(1);
   assign ptr_next = (CMP_W'(p_wide) >= CMP_W'(n)) ? '0 : PTR_W'(p_wide);
   assign old_ext  = vld_q_ff ? ACC_W'($signed(ram_rdata)) : '0;
   assign v_ext    = ACC_W'(v_ff);
   assign trial    = {rem_ff[REM_W-2:0], dq_ff[ACC_W-1]};
   assign qbit     = (trial >= REM_W'(n));
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.average    = avg_ff;
   assign rsp_bus.window_sum = wsum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wsize_ff     <= WSIZE_RESET;
         wp_ff        <= '0;
         acc_ff       <= '0;
         sum_n_ff     <= eff_size(WSIZE_RESET, MAX_WINDOW);
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wsize_ff     <= wsize_in;
         wp_ff        <= wp_in;
         acc_ff       <= acc_in;
         sum_n_ff     <= sum_n_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff  <= kind_in;
      v_ff     <= v_in;
      cnt_ff   <= cnt_in;
      dcnt_ff  <= dcnt_in;
      dq_ff    <= dq_in;
      rem_ff   <= rem_in;
      neg_ff   <= neg_in;
      vld_q_ff <= vld_q_in;
      avg_ff   <= avg_in;
      wsum_ff  <= wsum_in;
   end

   always_comb begin
      state_in     = state_ff;
      wsize_in     = csr_write_en ? csr_write_data : wsize_ff;
      wp_in        = wp_ff;
      acc_in       = acc_ff;
      sum_n_in     = sum_n_ff;
      kind_in      = kind_ff;
      v_in         = v_ff;
      cnt_in       = cnt_ff;
      dcnt_in      = dcnt_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      vld_in       = vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      avg_in       = avg_ff;
      wsum_in      = wsum_ff;
      ram_we       = 1'b0;
      ram_waddr    = PTR_W'(cnt_ff);
      ram_raddr    = PTR_W'(cnt_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               kind_in = req_kind_type'(req_bus.req_type);
               v_in    = req_bus.sample_value;
               cnt_in  = '0;
               if (req_kind_type'(req_bus.req_type) == REQ_FILL) begin
                  acc_in   = '0;
                  state_in = ST_FILL;
               end else begin
                  state_in = ST_LOOK;
               end
            end
         end
         ST_FILL: begin
            ram_we    = 1'b1;
            ram_waddr = PTR_W'(cnt_ff);
            vld_in[PTR_W'(cnt_ff)] = 1'b1;
            acc_in    = acc_ff + v_ext;
            cnt_in    = cnt_ff + WSIZE_BITS'(1);
            if (cnt_ff == n - WSIZE_BITS'(1)) begin
               sum_n_in = n;
               state_in = ST_PREP;
            end
         end
         ST_LOOK: begin
            ram_raddr = ptr_next;
            state_in  = ST_UPD;
         end
         ST_UPD: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_next;
            vld_in[ptr_next] = 1'b1;
            wp_in     = ptr_next;
            if (n == sum_n_ff) begin
               acc_in   = acc_ff - old_ext + v_ext;
               state_in = ST_PREP;
            end else begin
               acc_in   = '0;
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // read data is registered in the RAM, so it belongs to the previous address
            if (cnt_ff != '0) begin
               acc_in = acc_ff + old_ext;
            end
            cnt_in = cnt_ff + WSIZE_BITS'(1);
            if (cnt_ff == n) begin
               sum_n_in = n;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            neg_in   = acc_ff[ACC_W-1];
            dq_in    = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
            rem_in   = '0;
            dcnt_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = qbit ? (trial - REM_W'(n)) : trial;
            dq_in   = {dq_ff[ACC_W-2:0], qbit};
            dcnt_in = dcnt_ff + DCNT_W'(1);
            if (dcnt_ff == DCNT_W'(ACC_W - 1)) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               avg_in       = SAMPLE_BITS'(neg_ff ? -dq_ff : dq_ff);
               wsum_in      = SUM_BITS'(acc_ff);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      vld_q_in = vld_ff[ram_raddr];
   end

   `MAVG_ASSERT_NXT(a_busy_after_accept, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready)
   `MAVG_ASSERT_IMP(a_rem_below_size, clock, reset, state_ff == ST_DIV, rem_ff < REM_W'(n))
   `MAVG_ASSERT_IMP(a_result_from_hold, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_HOLD))
endmodule
